/* hdl/cds_pkg.sv */
`default_nettype none

package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int CNT_IN_W = 16;

    localparam logic [DAY_W-1:0]   RST_DAY   = 5'd29;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd2;
    localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2005;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_LEAP_FEB = 5'd29;
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

    // y / 100 == (y * 5243) >> 19 for every 14-bit y
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SH = 19;
    localparam int QUO_W     = 8;
    localparam int PROD_W    = YEAR_W + DIV100_MUL_W;
    localparam logic [YEAR_W-1:0] CENTURY = 14'd100;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP,
        ST_LOAD,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic at_limit;
        logic year_wrap;
    } t_step_stat;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? LEN_LEAP_FEB : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* hdl/cds_leap_unit.sv */
`default_nettype none

// Leap-year evaluator: registered reciprocal multiply, then a registered remainder check.
module cds_leap_unit (
    input  wire logic                      i_clk,
    input  wire logic [cds_pkg::YEAR_W-1:0] i_year,
    output logic                           o_leap
);
    import cds_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [YEAR_W-1:0] r_year;
    logic              r_leap;
    logic [QUO_W-1:0]  quo;
    logic [YEAR_W-1:0] hund;
    logic [YEAR_W-1:0] rem;
    logic              n_leap;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_year) * PROD_W'(DIV100_MUL);
        r_year <= i_year;
        r_leap <= n_leap;
    end

    always_comb begin
        quo  = r_prod[DIV100_SH +: QUO_W];
        hund = YEAR_W'(quo) * CENTURY;
        rem  = r_year - hund;
        // divisible by 400 means the century quotient is a multiple of 4
        n_leap = (r_year[1:0] == 2'b00) && ((rem != '0) || (quo[1:0] == 2'b00));
    end

    assign o_leap = r_leap;

endmodule

`default_nettype wire

/* hdl/cds_day_step.sv */
`default_nettype none

module cds_day_step #(
    parameter int MAX_YEAR = 9999
) (
    input  wire cds_pkg::t_date      i_date,
    input  wire logic                i_leap,
    input  wire logic                i_back,
    output cds_pkg::t_date           o_date,
    output cds_pkg::t_step_stat      o_stat
);
    import cds_pkg::*;

    localparam logic [YEAR_W-1:0] YEAR_TOP = YEAR_W'(MAX_YEAR);
    localparam logic [YEAR_W-1:0] YEAR_ONE = YEAR_W'(1);
    localparam logic [DAY_W-1:0]  DAY_ONE  = DAY_W'(1);

    logic [DAY_W-1:0]   cur_len;
    logic [MONTH_W-1:0] prev_month;
    logic               upper;
    logic               lower;

    always_comb begin
        cur_len    = month_len(i_date.month, i_leap);
        prev_month = i_date.month - MONTH_W'(1);
        upper = (i_date.year > YEAR_TOP) ||
                ((i_date.year == YEAR_TOP) && (i_date.month == MONTH_DEC) &&
                 (i_date.day >= LEN_LONG));
        lower = (i_date.year < YEAR_ONE) ||
                ((i_date.year == YEAR_ONE) && (i_date.month == MONTH_JAN) &&
                 (i_date.day <= DAY_ONE));

        o_date = i_date;
        o_stat.at_limit  = i_back ? lower : upper;
        o_stat.year_wrap = 1'b0;

        if (!i_back) begin
            if (i_date.day >= cur_len) begin
                o_date.day = DAY_ONE;
                if (i_date.month >= MONTH_DEC) begin
                    o_date.month     = MONTH_JAN;
                    o_date.year      = i_date.year + YEAR_W'(1);
                    o_stat.year_wrap = 1'b1;
                end else begin
                    o_date.month = i_date.month + MONTH_W'(1);
                end
            end else begin
                o_date.day = i_date.day + DAY_W'(1);
            end
        end else begin
            if (i_date.day <= DAY_ONE) begin
                if (i_date.month <= MONTH_JAN) begin
                    // December is never February, so the stale leap flag is harmless
                    o_date.month     = MONTH_DEC;
                    o_date.year      = i_date.year - YEAR_W'(1);
                    o_date.day       = LEN_LONG;
                    o_stat.year_wrap = 1'b1;
                end else begin
                    o_date.month = prev_month;
                    o_date.day   = month_len(prev_month, i_leap);
                end
            end else begin
                o_date.day = i_date.day - DAY_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/calendar_date_stepper_unit.sv */
`default_nettype none

// Channel  Dir  tdata (low bit up)                              tuser
// s        in   load_day[4:0] load_month[8:5] load_year[22:9]   operation[1:0]
//               day_count[38:23], pad to 40
// m        out  day_out[4:0] month_out[8:5] year_out[22:9],     error[0]
//               pad to 24
//
// Read goes from accept straight to the result state; load passes through the
// leap wait and the load check first. Add and subtract count N down: the
// day stepper advances one day a cycle, pausing for the leap evaluator at each
// year boundary crossed. o_s_tready is high only while idle.
// Synchronous active-low reset sets the date to 2005-02-29.
// A result waiting on i_m_tready holds the block in its final state.
module calendar_date_stepper_unit #(
    parameter int MAX_YEAR    = 9999,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // load_day, load_month, load_year, day_count
    input  wire logic [1:0]  i_s_tuser,   // operation
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // day_out, month_out, year_out
    output logic             o_m_tuser    // error
);
    import cds_pkg::*;

    localparam int CNT_TAKE = (COUNT_WIDTH < CNT_IN_W) ? COUNT_WIDTH : CNT_IN_W;
    localparam int LD_LO = 0;
    localparam int LM_LO = LD_LO + DAY_W;
    localparam int LY_LO = LM_LO + MONTH_W;
    localparam int CT_LO = LY_LO + YEAR_W;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [DAY_W-1:0]       r_ld;
    logic [MONTH_W-1:0]     r_lm;
    logic [YEAR_W-1:0]      r_ly;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    t_date                  r_date, n_date;
    logic                   r_err, n_err;
    logic                   r_wait, n_wait;
    t_date                  r_out_date;
    logic                   r_out_err;
    logic                   r_out_valid, n_out_valid;

    logic                   s_beat;
    logic                   out_free;
    logic                   leap;
    logic [YEAR_W-1:0]      leap_year_in;
    t_date                  step_date;
    t_step_stat             step_stat;
    logic                   load_ok;

    assign s_beat   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    assign leap_year_in = (r_op == OP_LOAD) ? r_ly : r_date.year;

    cds_leap_unit u_leap (
        .i_clk  (i_clk),
        .i_year (leap_year_in),
        .o_leap (leap)
    );

    cds_day_step #(
        .MAX_YEAR (MAX_YEAR)
    ) u_step (
        .i_date (r_date),
        .i_leap (leap),
        .i_back (r_op == OP_SUB),
        .o_date (step_date),
        .o_stat (step_stat)
    );

    assign load_ok = (r_lm >= MONTH_JAN) && (r_lm <= MONTH_DEC) &&
                     (r_ly >= YEAR_W'(1)) && (r_ly <= YEAR_W'(MAX_YEAR)) &&
                     (r_ld >= DAY_W'(1)) && (r_ld <= month_len(r_lm, leap));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_beat) begin
                    n_state = (t_op'(i_s_tuser) == OP_READ) ? ST_DONE : ST_LEAP;
                end
            end
            ST_LEAP: begin
                if (r_wait) begin
                    n_state = (r_op == OP_LOAD) ? ST_LOAD : ST_STEP;
                end
            end
            ST_LOAD: n_state = ST_DONE;
            ST_STEP: begin
                if ((r_cnt == '0) || step_stat.at_limit) begin
                    n_state = ST_DONE;
                end else if (step_stat.year_wrap) begin
                    n_state = ST_LEAP;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_date      = r_date;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_wait      = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        o_s_tready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                n_err      = 1'b0;
                n_cnt      = COUNT_WIDTH'(i_s_tdata[CT_LO +: CNT_TAKE]);
            end
            ST_LEAP: n_wait = !r_wait;
            ST_LOAD: begin
                if (load_ok) begin
                    n_date.day   = r_ld;
                    n_date.month = r_lm;
                    n_date.year  = r_ly;
                end else begin
                    n_err = 1'b1;
                end
            end
            ST_STEP: begin
                if (r_cnt != '0) begin
                    if (step_stat.at_limit) begin
                        n_err = 1'b1;
                    end else begin
                        n_date = step_date;
                        n_cnt  = r_cnt - COUNT_WIDTH'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: n_wait = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_date.day   <= RST_DAY;
            r_date.month <= RST_MONTH;
            r_date.year  <= RST_YEAR;
            r_wait       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_date      <= n_date;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: capture the beat, hold the count and flag, latch the result
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_err <= n_err;
        if (s_beat) begin
            r_op <= t_op'(i_s_tuser);
            r_ld <= i_s_tdata[LD_LO +: DAY_W];
            r_lm <= i_s_tdata[LM_LO +: MONTH_W];
            r_ly <= i_s_tdata[LY_LO +: YEAR_W];
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_date <= r_date;
            r_out_err  <= r_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_date.year, r_out_date.month, r_out_date.day};
    assign o_m_tuser  = r_out_err;

endmodule

`default_nettype wire

/* verif/calendar_date_checker.sv */
module calendar_date_checker #(
    parameter int MAX_YEAR    = 9999,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,   // load_day, load_month, load_year, day_count
    input  wire logic [1:0]  i_s_tuser,   // operation
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // day_out, month_out, year_out
    input  wire logic        i_m_tuser,   // error
    output int               o_fail_cnt,
    output int               o_pending
);
    import cds_pkg::*;

    typedef struct packed {
        t_date date;
        logic  err;
    } t_date_reply;

    t_date_reply replies_due[$];
    t_date       cal = {RST_YEAR, RST_MONTH, RST_DAY};
    int          fails = 0;
    int          pend = 0;
    int          n_replies = 0;

    assign o_fail_cnt = fails;
    assign o_pending  = pend;

    task automatic report_mismatch(input string msg);
        $display("%0t checker: %s", $time, msg);
        fails++;
    endtask

    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in(input int m, input int y);
        if (m == int'(MONTH_FEB))
            return is_leap(y) ? int'(LEN_LEAP_FEB) : int'(LEN_FEB);
        if (m == int'(MONTH_APR) || m == int'(MONTH_JUN) || m == int'(MONTH_SEP) ||
            m == int'(MONTH_NOV))
            return int'(LEN_SHORT);
        return int'(LEN_LONG);
    endfunction

    // Advance the held date by one beat and return the reply it must produce.
    task automatic predict_date(input t_op op, input int ld, input int lm, input int ly,
                                input longint cnt, output t_date_reply r);
        int     d;
        int     m;
        int     y;
        longint n;
        logic   e;
        d = int'(cal.day);
        m = int'(cal.month);
        y = int'(cal.year);
        n = cnt & ((64'd1 << COUNT_WIDTH) - 1);
        e = 1'b0;
        case (op)
            OP_LOAD: begin
                if (lm >= int'(MONTH_JAN) && lm <= int'(MONTH_DEC) && ly >= 1 &&
                    ly <= MAX_YEAR && ld >= 1 && ld <= days_in(lm, ly)) begin
                    d = ld;
                    m = lm;
                    y = ly;
                end else begin
                    e = 1'b1;
                end
            end
            OP_ADD: begin
                while (n > 0 && !e) begin
                    if (y > MAX_YEAR ||
                        (y == MAX_YEAR && m == int'(MONTH_DEC) && d >= int'(LEN_LONG))) begin
                        e = 1'b1;
                    end else begin
                        // a day at or past the month end rolls to the 1st
                        if (d >= days_in(m, y)) begin
                            d = 1;
                            if (m >= int'(MONTH_DEC)) begin
                                m = int'(MONTH_JAN);
                                y++;
                            end else begin
                                m++;
                            end
                        end else begin
                            d++;
                        end
                        n--;
                    end
                end
            end
            OP_SUB: begin
                while (n > 0 && !e) begin
                    if (y < 1 || (y == 1 && m == int'(MONTH_JAN) && d <= 1)) begin
                        e = 1'b1;
                    end else begin
                        if (d <= 1) begin
                            if (m <= int'(MONTH_JAN)) begin
                                m = int'(MONTH_DEC);
                                y--;
                            end else begin
                                m--;
                            end
                            d = days_in(m, y);
                        end else begin
                            d--;
                        end
                        n--;
                    end
                end
            end
            default: ;
        endcase
        cal.day   = d[DAY_W-1:0];
        cal.month = m[MONTH_W-1:0];
        cal.year  = y[YEAR_W-1:0];
        r.date    = cal;
        r.err     = e;
    endtask

    always @(posedge i_clk) begin
        t_date_reply want;
        t_date_reply got;
        if (!i_rst_n) begin
            cal = {RST_YEAR, RST_MONTH, RST_DAY};
            replies_due.delete();
        end else begin
            // drain the output side first: a reply never belongs to a beat
            // accepted on the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.date = i_m_tdata[YEAR_W+MONTH_W+DAY_W-1:0];
                got.err  = i_m_tuser;
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("reply %0d arrived with nothing expected",
                                              n_replies));
                end else begin
                    want = replies_due.pop_front();
                    if (got.date.day !== want.date.day)
                        report_mismatch($sformatf("reply %0d day %0d, expected %0d",
                                                  n_replies, got.date.day, want.date.day));
                    if (got.date.month !== want.date.month)
                        report_mismatch($sformatf("reply %0d month %0d, expected %0d",
                                                  n_replies, got.date.month,
                                                  want.date.month));
                    if (got.date.year !== want.date.year)
                        report_mismatch($sformatf("reply %0d year %0d, expected %0d",
                                                  n_replies, got.date.year, want.date.year));
                    if (got.err !== want.err)
                        report_mismatch($sformatf("reply %0d error %b, expected %b",
                                                  n_replies, got.err, want.err));
                end
                n_replies++;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_date(t_op'(i_s_tuser), int'(i_s_tdata[4:0]), int'(i_s_tdata[8:5]),
                             int'(i_s_tdata[22:9]), longint'(i_s_tdata[38:23]), want);
                replies_due.push_back(want);
            end
        end
        pend = replies_due.size();
    end

endmodule

/* verif/tb_calendar_date_stepper_unit.sv */
module tb_calendar_date_stepper_unit;
    import cds_pkg::*;

    localparam int MAX_YEAR     = 9999;
    localparam int COUNT_WIDTH  = 16;
    localparam int NUM_RANDOM   = 75;
    localparam int HOLD_AT      = 30;
    localparam int QUIET_AT     = 60;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    // Ends a hung run; sized for two full-count steps plus 75 random steps,
    // all stalls included.
    localparam int CYCLE_LIMIT  = 4_000_000;

    typedef struct {
        t_op                op;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [CNT_IN_W-1:0] count;
    } t_date_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // load_day, load_month, load_year, day_count
    logic [1:0]  i_s_tuser;   // operation
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // day_out, month_out, year_out
    logic        o_m_tuser;   // error

    int fail_cnt;
    int pending;
    int cycles = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    calendar_date_stepper_unit #(
        .MAX_YEAR    (MAX_YEAR),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    calendar_date_checker #(
        .MAX_YEAR    (MAX_YEAR),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_calendar_date_stepper_unit: FAIL");
            $finish;
        end
    end

    // Result side: short random stalls, one long hold on request.
    initial begin
        int stall;
        bit held;
        stall = 0;
        held = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                stall = LONG_HOLD;
            end else if (stall == 0 && idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 3);
            end
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic t_date_cmd date_cmd(input t_op op, input int d, input int m,
                                           input int y, input int n);
        t_date_cmd c;
        c.op    = op;
        c.day   = d[DAY_W-1:0];
        c.month = m[MONTH_W-1:0];
        c.year  = y[YEAR_W-1:0];
        c.count = n[CNT_IN_W-1:0];
        return c;
    endfunction

    // Entered and left at a falling edge; valid stays high into the next beat
    // unless a gap is drawn.
    task automatic send_cmd(input t_date_cmd c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.op;
        i_s_tdata  <= {1'b0, c.count, c.year, c.month, c.day};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    initial begin
        t_date_cmd c;
        int        pick;
        int        r;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_READ;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset date is Feb 29 of a common year; read ignores every field
        send_cmd(date_cmd(OP_READ, 31, 15, 16383, 65535));
        send_cmd(date_cmd(OP_ADD, 0, 0, 0, 1));
        send_cmd(date_cmd(OP_ADD, 0, 0, 0, 0));
        send_cmd(date_cmd(OP_SUB, 31, 15, 16383, 0));
        // rejected loads: bad month, day, leap day, year
        send_cmd(date_cmd(OP_LOAD, 15, 0, 2000, 65535));
        send_cmd(date_cmd(OP_LOAD, 15, 13, 2000, 0));
        send_cmd(date_cmd(OP_LOAD, 31, 4, 2001, 0));
        send_cmd(date_cmd(OP_LOAD, 0, 5, 2001, 0));
        send_cmd(date_cmd(OP_LOAD, 29, 2, 1900, 0));
        send_cmd(date_cmd(OP_LOAD, 1, 1, 0, 0));
        send_cmd(date_cmd(OP_LOAD, 1, 1, 10000, 0));
        send_cmd(date_cmd(OP_LOAD, 31, 15, 16383, 0));
        send_cmd(date_cmd(OP_LOAD, 29, 2, 2000, 0));
        send_cmd(date_cmd(OP_LOAD, 28, 2, 2100, 0));
        send_cmd(date_cmd(OP_ADD, 0, 0, 0, 1));
        // upper limit: reach it exactly, then run into it
        send_cmd(date_cmd(OP_LOAD, 30, 12, MAX_YEAR, 0));
        send_cmd(date_cmd(OP_ADD, 0, 0, 0, 1));
        send_cmd(date_cmd(OP_ADD, 0, 0, 0, 65535));
        // lower limit
        send_cmd(date_cmd(OP_LOAD, 2, 1, 1, 0));
        send_cmd(date_cmd(OP_SUB, 0, 0, 0, 1));
        send_cmd(date_cmd(OP_SUB, 0, 0, 0, 5));
        send_cmd(date_cmd(OP_LOAD, 1, 3, 1, 0));
        send_cmd(date_cmd(OP_SUB, 0, 0, 0, 65535));
        // full count across many leap years and back
        send_cmd(date_cmd(OP_LOAD, 1, 1, 2000, 0));
        send_cmd(date_cmd(OP_ADD, 0, 0, 0, 65535));
        send_cmd(date_cmd(OP_SUB, 0, 0, 0, 65535));

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == HOLD_AT)
                hold_req = 1'b1;
            if (i == QUIET_AT)
                idle_on = 1'b0;
            c.day   = DAY_W'($urandom);
            c.month = MONTH_W'($urandom);
            c.year  = YEAR_W'($urandom);
            c.count = CNT_IN_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                c.op    = OP_LOAD;
                c.month = MONTH_W'($urandom_range(1, 12));
                c.day   = DAY_W'(($urandom_range(0, 4) == 0) ? $urandom_range(29, 31)
                                                             : $urandom_range(1, 28));
                if ($urandom_range(0, 2) == 0) begin
                    // park near either end so later steps hit the limits
                    if ($urandom_range(0, 1) == 0) begin
                        c.year  = YEAR_W'($urandom_range(1, 2));
                        c.month = MONTH_JAN;
                    end else begin
                        c.year  = YEAR_W'($urandom_range(MAX_YEAR - 1, MAX_YEAR));
                        c.month = MONTH_DEC;
                    end
                end else begin
                    c.year = YEAR_W'($urandom_range(1, MAX_YEAR));
                end
            end else if (pick < 28) begin
                c.op = OP_LOAD;
            end else if (pick < 40) begin
                c.op = OP_READ;
            end else begin
                c.op = pick[0] ? OP_ADD : OP_SUB;
                r = $urandom_range(0, 99);
                if (r < 70)
                    c.count = CNT_IN_W'($urandom_range(0, 40));
                else if (r < 93)
                    c.count = CNT_IN_W'($urandom_range(0, 1500));
                else
                    c.count = CNT_IN_W'($urandom_range(0, 8000));
            end
            send_cmd(c);
        end
        i_s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("tb_calendar_date_stepper_unit: PASS");
        end else begin
            if (pending != 0)
                $display("%0d replies never arrived", pending);
            $display("tb_calendar_date_stepper_unit: FAIL");
        end
        $finish;
    end

endmodule
